// ===== src/csg_pkg.sv =====
// csg_pkg: shared types, codes and the sine quarter-table builder for the
// contour sine generator. No dependencies.
package csg_pkg;

    localparam int unsigned CONTOUR_DEPTH_DEF   = 256;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_UNDEF   = 2'd3;

    localparam logic [1:0] REG_TOTAL   = 2'd0;
    localparam logic [1:0] REG_POINTS  = 2'd1;
    localparam logic [1:0] REG_COLLAR  = 2'd2;
    localparam logic [1:0] REG_PPFU    = 2'd3;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam logic [63:0] PEAK        = 64'd7000;

    typedef struct packed {
        logic cap;
        logic do_load;
        logic do_restart;
        logic eval;
        logic start_idx;
        logic rd_mem;
        logic mul_inc;
        logic start_ramp;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       ended;
        logic       silent;
        logic       ramp;
        logic       div_done;
        logic       out_full;
    } t_status;

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // floor(a / b) by shift and subtract, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], a[k]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // trunc(7000 * sin(r / 2^qbits * pi/2)), elaboration only
    function automatic logic [12:0] quarter_value(input int unsigned qbits,
                                                  input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int unsigned i;
        if (r >= (32'd1 << qbits)) begin
            return 13'd7000;
        end
        x    = (HALF_PI_Q62 >> qbits) * 64'(r);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (i = 1; i < 30; i++) begin
            term = udiv64(mul_q62(term, x2), 64'(2 * i) * 64'(2 * i + 1));
            if (i[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = mul_q62(sum, PEAK);
        return v[12:0];
    endfunction

endpackage

// ===== src/csg_in_if.sv =====
// csg_in_if: input item channel of the contour sine generator.
// No dependencies.
interface csg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  entry_index;
    logic [15:0] entry_freq;
    modport source(output valid, output operation, output entry_index,
                   output entry_freq, input ready);
    modport sink(input valid, input operation, input entry_index,
                 input entry_freq, output ready);
endinterface

// ===== src/csg_out_if.sv =====
// csg_out_if: result item channel of the contour sine generator.
// No dependencies.
interface csg_out_if;
    logic              valid;
    logic              ready;
    logic signed [13:0] sample;
    logic              last_sample;
    logic              ended;
    modport source(output valid, output sample, output last_sample,
                   output ended, input ready);
    modport sink(input valid, input sample, input last_sample,
                 input ended, output ready);
endinterface

// ===== src/csg_cfg_if.sv =====
// csg_cfg_if: register write channel of the contour sine generator.
// No dependencies.
interface csg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/contour_sine_generator.sv =====
// contour_sine_generator: top level, joins controller and datapath.
// Depends on csg_pkg, the three channel interfaces, csg_ctrl, csg_datapath.
//
//  channel   dir  payload                               handshake
//  i_item    in   operation, entry_index, entry_freq    valid/ready
//  o_result  out  sample, last_sample, ended            valid/ready
//  i_cfg     in   index, data (register write)          valid/ready, always ready
//
// one item at a time: load, restart and undefined codes are captured, decoded and done
// a sample item runs the 33-step contour index divider
// inside a fade ramp the same divider runs again for the ramp scaling
// silent and ended samples skip both divisions; a stalled result holds the next one
// reset: synchronous, active low; the contour store keeps no reset
module contour_sine_generator
    import csg_pkg::*;
#(
    parameter int unsigned CONTOUR_DEPTH   = CONTOUR_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csg_in_if.sink     i_item,
    csg_out_if.source  o_result,
    csg_cfg_if.sink    i_cfg
);
    t_cmd    w_cmd;
    t_status w_status;

    assign i_cfg.ready = 1'b1;

    csg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    csg_datapath #(
        .CONTOUR_DEPTH   (CONTOUR_DEPTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_operation   (i_item.operation),
        .i_entry_index (i_item.entry_index),
        .i_entry_freq  (i_item.entry_freq),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_sample      (o_result.sample),
        .o_last_sample (o_result.last_sample),
        .o_ended       (o_result.ended)
    );
endmodule

// ===== src/csg_ram.sv =====
// csg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module csg_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/csg_div.sv =====
// csg_div: unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module csg_div #(
    parameter int unsigned N = 33,
    parameter int unsigned D = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic [N-1:0] o_quotient,
    output logic         o_done
);
    localparam int unsigned CW = $clog2(N + 1);

    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [D:0]    w_shift;
    logic          w_ge;
    logic [D:0]    w_diff;

    assign w_shift = {r_rem, r_quo[N-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(N);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[N-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D-1:0] : w_shift[D-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule

// ===== src/csg_datapath.sv =====
// csg_datapath: registers, phase accumulator, sine table, contour store and
// shared divider. Depends on csg_pkg, csg_ram, csg_div.
module csg_datapath
    import csg_pkg::*;
#(
    parameter int unsigned CONTOUR_DEPTH   = CONTOUR_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_entry_index,
    input  logic [15:0]        i_entry_freq,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [13:0] o_sample,
    output logic               o_last_sample,
    output logic               o_ended
);
    localparam int unsigned AW = $clog2(CONTOUR_DEPTH);
    localparam int unsigned QB = SINE_TABLE_BITS - 2;
    localparam int unsigned QS = 1 << QB;
    localparam int unsigned NW = 33;

    logic [23:0] r_total;
    logic [8:0]  r_points;
    logic [15:0] r_collar;
    logic [31:0] r_ppfu;
    logic [23:0] r_count;
    logic [31:0] r_phase;
    logic [31:0] r_inc;
    logic [1:0]  r_op;
    logic [7:0]  r_idx;
    logic [15:0] r_freq;
    logic [12:0] r_tmag;
    logic        r_tneg;
    logic [15:0] r_m;
    logic        r_ramp;
    logic        r_out_valid;
    logic signed [13:0] r_sample;
    logic        r_last;
    logic        r_ended;

    logic [12:0] w_sine_q [QS + 1];
    logic [SINE_TABLE_BITS-1:0] w_tidx;
    logic [QB:0] w_qr;
    logic signed [25:0] w_hi_lim;
    logic [NW-1:0] w_prod;
    logic [28:0] w_ramp_num;
    logic [NW-1:0] w_dividend;
    logic [23:0] w_divisor;
    logic [NW-1:0] w_quo;
    logic        w_done;
    logic [AW-1:0] w_rd_addr;
    logic [31:0] w_wr_ext;
    logic [15:0] w_rd_data;
    logic [47:0] w_inc_full;
    logic [23:0] w_count_nx;
    logic signed [13:0] w_full;
    logic signed [13:0] w_rampv;

    for (genvar g = 0; g <= QS; g++) begin : g_sine
        localparam logic [12:0] VAL = quarter_value(QB, g);
        assign w_sine_q[g] = VAL;
    end

    // quarter-wave symmetry on the table index
    assign w_tidx = r_phase[31 -: SINE_TABLE_BITS];
    assign w_qr   = w_tidx[QB] ? ((QB + 1)'(QS) - {1'b0, w_tidx[QB-1:0]})
                               : {1'b0, w_tidx[QB-1:0]};
    assign w_hi_lim = $signed({2'b0, r_total}) - $signed({10'b0, r_collar});

    assign w_prod     = NW'(r_count) * NW'(r_points);
    assign w_ramp_num = 29'(r_tmag) * 29'(r_m);
    assign w_dividend = i_cmd.start_idx ? w_prod : NW'(w_ramp_num);
    assign w_divisor  = i_cmd.start_idx ? r_total : 24'(r_collar);

    csg_div #(.N(NW), .D(24)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_idx | i_cmd.start_ramp),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_done)
    );

    assign w_rd_addr = (w_quo >= NW'(CONTOUR_DEPTH - 1)) ? AW'(CONTOUR_DEPTH - 1)
                                                         : w_quo[AW-1:0];
    assign w_wr_ext  = 32'(r_idx);

    csg_ram #(.WIDTH(16), .DEPTH(CONTOUR_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.do_load && (w_wr_ext < 32'(CONTOUR_DEPTH))),
        .i_wr_addr (w_wr_ext[AW-1:0]),
        .i_wr_data (r_freq),
        .i_rd_en   (i_cmd.rd_mem),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_inc_full = 48'(w_rd_data) * 48'(r_ppfu);
    assign w_count_nx = r_count + 24'd1;
    assign w_full     = r_tneg ? -$signed({1'b0, r_tmag}) : $signed({1'b0, r_tmag});
    assign w_rampv    = r_tneg ? -$signed({1'b0, w_quo[12:0]})
                               : $signed({1'b0, w_quo[12:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_points    <= '0;
            r_collar    <= 16'd320;
            r_ppfu      <= 32'd1099511628;
            r_count     <= '0;
            r_phase     <= '0;
            r_op        <= OP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TOTAL:  r_total  <= i_cfg_data[23:0];
                    REG_POINTS: r_points <= i_cfg_data[8:0];
                    REG_COLLAR: r_collar <= i_cfg_data[15:0];
                    REG_PPFU:   r_ppfu   <= i_cfg_data;
                    default:    r_ppfu   <= r_ppfu;
                endcase
            end
            if (i_cmd.cap) begin
                r_op <= i_operation;
            end
            if (i_cmd.do_restart) begin
                r_count <= '0;
                r_phase <= '0;
            end
            if (i_cmd.commit && !o_status.ended) begin
                r_count <= w_count_nx;
                if (!o_status.silent) begin
                    r_phase <= r_phase + r_inc;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_idx  <= i_entry_index;
            r_freq <= i_entry_freq;
        end
        if (i_cmd.eval) begin
            r_tmag <= w_sine_q[w_qr];
            r_tneg <= w_tidx[QB+1];
            if (r_count < 24'(r_collar)) begin
                r_ramp <= 1'b1;
                r_m    <= r_count[15:0];
            end else if ($signed({2'b0, r_count}) < w_hi_lim) begin
                r_ramp <= 1'b0;
                r_m    <= r_count[15:0];
            end else begin
                r_ramp <= 1'b1;
                r_m    <= 16'(r_total - r_count);
            end
        end
        if (i_cmd.mul_inc) begin
            r_inc <= w_inc_full[47:16];
        end
        if (i_cmd.commit) begin
            if (o_status.ended) begin
                r_sample <= '0;
                r_last   <= 1'b0;
                r_ended  <= 1'b1;
            end else begin
                r_last  <= (w_count_nx == r_total);
                r_ended <= 1'b0;
                if (o_status.silent) begin
                    r_sample <= '0;
                end else if (r_ramp) begin
                    r_sample <= w_rampv;
                end else begin
                    r_sample <= w_full;
                end
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.ended    = r_count >= r_total;
    assign o_status.silent   = r_points == 9'd0;
    assign o_status.ramp     = r_ramp;
    assign o_status.div_done = w_done;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_sample;
    assign o_last_sample = r_last;
    assign o_ended       = r_ended;
endmodule

// ===== src/csg_ctrl.sv =====
// csg_ctrl: sequencing state machine for the contour sine generator.
// Depends on csg_pkg.
module csg_ctrl
    import csg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_DIVI = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIVR = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_status.op)
                    OP_LOAD: begin
                        o_cmd.do_load = 1'b1;
                        n_state       = S_IDLE;
                    end
                    OP_RESTART: begin
                        o_cmd.do_restart = 1'b1;
                        n_state          = S_IDLE;
                    end
                    OP_SAMPLE: begin
                        o_cmd.eval = 1'b1;
                        if (i_status.ended || i_status.silent) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.start_idx = 1'b1;
                            n_state         = S_DIVI;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIVI: begin
                if (i_status.div_done) begin
                    o_cmd.rd_mem = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_inc = 1'b1;
                if (i_status.ramp) begin
                    o_cmd.start_ramp = 1'b1;
                    n_state          = S_DIVR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIVR: begin
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // output register frees when the pending item is taken
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

// ===== dv/csg_checker.sv =====
// csg_checker: watches the item, result and register channels of the contour
// sine generator, predicts each result and compares. Depends on csg_pkg and the
// three channel interfaces.
module csg_checker
    import csg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    csg_in_if         item_ch,
    csg_out_if        result_ch,
    csg_cfg_if        cfg_ch,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL_BITS = 10;
    localparam int unsigned Q_BITS   = TBL_BITS - 2;
    localparam int unsigned DEPTH    = 256;
    localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;

    typedef struct packed {
        logic signed [13:0] sample;
        logic               last_sample;
        logic               ended;
    } t_tone_out;

    int          sine_lut [1 << TBL_BITS];
    logic [15:0] freq_store [DEPTH];
    logic [23:0] n_done;
    logic [31:0] osc_phase;
    logic [23:0] len_cfg;
    logic [8:0]  points_cfg;
    logic [15:0] collar_cfg;
    logic [31:0] step_cfg;
    t_tone_out   tone_q [$];

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // taylor series of sin over the first quarter, truncated
    function automatic int quarter_amp(input int unsigned r);
        logic [63:0] x, x2, term, acc;
        if (r >= (1 << Q_BITS)) begin
            return 7000;
        end
        x    = (QUARTER_TURN_Q62 >> Q_BITS) * 64'(r);
        x2   = qmul(x, x);
        term = x;
        acc  = x;
        for (int i = 1; i < 30; i++) begin
            term = qmul(term, x2) / (64'(2 * i) * 64'(2 * i + 1));
            if (i % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return int'(qmul(acc, 64'd7000));
    endfunction

    initial begin
        int unsigned q, r;
        for (int k = 0; k < (1 << TBL_BITS); k++) begin
            q = k >> Q_BITS;
            r = k & ((1 << Q_BITS) - 1);
            if (q == 1 || q == 3) begin
                r = (1 << Q_BITS) - r;
            end
            sine_lut[k] = (q >= 2) ? -quarter_amp(r) : quarter_amp(r);
        end
    end

    function automatic t_tone_out next_sample();
        t_tone_out   res;
        longint      n, len, col, t, s;
        longint unsigned fi, inc;
        res = '0;
        if (n_done >= len_cfg) begin
            res.ended = 1'b1;
            return res;
        end
        n   = longint'(n_done);
        len = longint'(len_cfg);
        col = longint'(collar_cfg);
        s   = 0;
        if (points_cfg != 0) begin
            t = longint'(sine_lut[osc_phase[31:32-TBL_BITS]]);
            if (n < col) begin
                s = (t * n) / col;
            end else if (n < len - col) begin
                s = t;
            end else begin
                s = (t * (len - n)) / col;
            end
            fi = (64'(n_done) * 64'(points_cfg)) / 64'(len_cfg);
            if (fi >= DEPTH) begin
                fi = DEPTH - 1;
            end
            inc = (64'(freq_store[fi]) * 64'(step_cfg)) >> 16;
            osc_phase = osc_phase + inc[31:0];
        end
        n_done = n_done + 24'd1;
        res.sample      = s[13:0];
        res.last_sample = (n_done == len_cfg);
        return res;
    endfunction

    assign o_pending = tone_q.size();

    always @(posedge i_clk) begin
        t_tone_out want;
        if (!i_rst_n) begin
            n_done     <= '0;
            osc_phase  <= '0;
            len_cfg    <= '0;
            points_cfg <= '0;
            collar_cfg <= 16'd320;
            step_cfg   <= 32'd1099511628;
            o_errors   <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (tone_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time,
                             {result_ch.sample, result_ch.last_sample, result_ch.ended});
                    o_errors <= o_errors + 1;
                end else begin
                    want = tone_q.pop_front();
                    if (want.sample !== result_ch.sample
                            || want.last_sample !== result_ch.last_sample
                            || want.ended !== result_ch.ended) begin
                        $display({"%0t: result: expected sample %0d last %b ended %b,",
                                  " actual sample %0d last %b ended %b"},
                                 $time, want.sample, want.last_sample, want.ended,
                                 result_ch.sample, result_ch.last_sample, result_ch.ended);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_TOTAL:  len_cfg    = cfg_ch.data[23:0];
                    REG_POINTS: points_cfg = cfg_ch.data[8:0];
                    REG_COLLAR: collar_cfg = cfg_ch.data[15:0];
                    REG_PPFU:   step_cfg   = cfg_ch.data;
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready) begin
                case (item_ch.operation)
                    OP_LOAD: freq_store[item_ch.entry_index] = item_ch.entry_freq;
                    OP_RESTART: begin
                        n_done    = '0;
                        osc_phase = '0;
                    end
                    OP_SAMPLE: tone_q.push_back(next_sample());
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/tb_contour_sine_generator.sv =====
// tb_contour_sine_generator: stimulus and verdict for the contour sine generator.
// Depends on csg_pkg, the channel interfaces, csg_checker and the block.
module tb_contour_sine_generator;
    import csg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   items_sent = 0;
    int   cycles = 0;
    logic rx_en = 1'b0;
    logic hold_off = 1'b0;
    logic hold_req = 1'b0;

    csg_in_if  item_ch();
    csg_out_if result_ch();
    csg_cfg_if cfg_ch();

    contour_sine_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch), .o_result(result_ch), .i_cfg(cfg_ch)
    );

    csg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .item_ch(item_ch), .result_ch(result_ch), .cfg_ch(cfg_ch),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    assign result_ch.ready = rx_en & ~hold_off;

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.operation   = OP_LOAD;
        item_ch.entry_index = '0;
        item_ch.entry_freq  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_TOTAL;
        cfg_ch.data         = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver with random stalls
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                rx_en <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_en <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // one long hold-off so the block backs up onto its input
    initial begin
        @(posedge i_clk iff hold_req);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                             input logic [15:0] freq, input bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.entry_index <= idx;
        item_ch.entry_freq  <= freq;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        items_sent++;
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    task automatic run_tone(input logic [23:0] len, input logic [8:0] pts,
                            input logic [15:0] col, input logic [31:0] step,
                            input int n_samples, input bit noisy);
        int pick;
        drain();
        write_reg(REG_TOTAL, 32'(len));
        write_reg(REG_POINTS, 32'(pts));
        write_reg(REG_COLLAR, 32'(col));
        write_reg(REG_PPFU, step);
        cfg_ch.valid <= 1'b0;
        send_item(OP_RESTART, 8'($urandom), 16'($urandom), 1'b0);
        for (int i = 0; i < n_samples; i++) begin
            pick = noisy ? $urandom_range(0, 99) : 99;
            if (pick < 8) begin
                send_item(OP_LOAD, 8'($urandom), 16'($urandom), 1'b0);
            end else if (pick < 10) begin
                send_item(OP_RESTART, 8'($urandom), 16'($urandom), 1'b0);
            end else if (pick < 12) begin
                send_item(OP_UNDEF, 8'($urandom), 16'($urandom), 1'b0);
            end
            send_item(OP_SAMPLE, 8'($urandom), 16'($urandom), i % 5 == 0);
        end
    endtask

    initial begin
        int len, pts, col;
        logic [31:0] step;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: zero length, so a sample reports an ended tone
        send_item(OP_SAMPLE, 8'hFF, 16'hFFFF, 1'b0);
        send_item(OP_UNDEF, 8'hFF, 16'hFFFF, 1'b0);
        send_item(OP_RESTART, 8'h00, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'h00, 16'h0000, 1'b0);
        send_item(OP_LOAD, 8'hFF, 16'hFFFF, 1'b0);
        send_item(OP_SAMPLE, 8'h00, 16'h0000, 1'b1);
        // every contour entry gets written before any tone reads it
        for (int k = 1; k < 255; k++) begin
            send_item(OP_LOAD, 8'(k), (k % 17 == 0) ? 16'hFFFF : 16'($urandom), 1'b0);
        end

        run_tone(24'd40, 9'd256, 16'd10, 32'd1099511628, 42, 1'b0);
        run_tone(24'd30, 9'd0, 16'd0, 32'd1099511628, 32, 1'b0);
        run_tone(24'hFFFFFF, 9'd1, 16'hFFFF, 32'hFFFFFFFF, 20, 1'b0);
        run_tone(24'd50, 9'd3, 16'd30, 32'd0, 52, 1'b0);
        run_tone(24'd1, 9'd256, 16'd0, 32'($urandom), 3, 1'b0);

        hold_req <= 1'b1;
        while (items_sent < ITEM_TARGET) begin
            len  = $urandom_range(1, 120);
            pts  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 256);
            col  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, len);
            step = ($urandom_range(0, 5) == 0) ? 32'hFFFFFFFF : 32'($urandom);
            run_tone(24'(len), 9'(pts), 16'(col), step, len + $urandom_range(0, 3), 1'b1);
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/csg_pkg.sv
src/csg_in_if.sv
src/csg_out_if.sv
src/csg_cfg_if.sv
src/csg_ram.sv
src/csg_div.sv
src/csg_datapath.sv
src/csg_ctrl.sv
src/contour_sine_generator.sv
dv/csg_checker.sv
dv/tb_contour_sine_generator.sv
